// File: sv/id_whitelist_table_assert.svh
// ----------------------------------------------------------------------------
// id_whitelist_table assertion macros
// Shorthand for clocked checks that are disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef ID_WHITELIST_TABLE_ASSERT_SVH
`define ID_WHITELIST_TABLE_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define IDWL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define IDWL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/idwl_pkg.sv
// ----------------------------------------------------------------------------
// idwl_pkg
// Shared constants, types and the key cleanup function of the ID table.
// ----------------------------------------------------------------------------
package idwl_pkg;

  localparam int ENTRIES   = 256;
  localparam int KEY_BYTES = 24;
  localparam int MAX_CHARS = 23;
  localparam int CHAR_LIMIT = (KEY_BYTES - 1 < MAX_CHARS) ? KEY_BYTES - 1 : MAX_CHARS;

  localparam int KEY_W   = MAX_CHARS * 8;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int FUNC_W  = 2;
  localparam int OCNT_W  = 9;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

  typedef logic [KEY_W-1:0] key_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    FEED_ROTATE,
    FEED_NEXT,
    FEED_KEY
  } feed_sel_t;

  typedef struct packed {
    logic      shift_en;
    feed_sel_t feed_sel;
  } ring_ctrl_t;

  typedef struct packed {
    logic              found;
    logic              status;
    logic [OCNT_W-1:0] entry_count;
  } res_t;

  // Keep characters up to the first zero byte and within the length limit.
  function automatic key_t normalize_key(input logic [63:0] w0, input logic [63:0] w1,
                                         input logic [55:0] w2);
    logic [KEY_W-1:0] raw;
    logic             ended;
    key_t             k;
    raw   = {w2, w1, w0};
    ended = 1'b0;
    k     = '0;
    for (int i = 0; i < MAX_CHARS; i++) begin
      if (i >= CHAR_LIMIT || raw[i*8 +: 8] == 8'h00) begin
        ended = 1'b1;
      end
      if (!ended) begin
        k[i*8 +: 8] = raw[i*8 +: 8];
      end
    end
    return k;
  endfunction

endpackage

// File: sv/idwl_if.sv
// ----------------------------------------------------------------------------
// idwl channel interfaces
// Valid/ready channels for request and response transactions.
// ----------------------------------------------------------------------------
interface idwl_in_if import idwl_pkg::*;;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [63:0]       key_word0;
  logic [63:0]       key_word1;
  logic [55:0]       key_word2;

  modport source (output valid, output func, output key_word0, output key_word1,
                  output key_word2, input ready);
  modport sink   (input valid, input func, input key_word0, input key_word1,
                  input key_word2, output ready);
endinterface

interface idwl_out_if import idwl_pkg::*;;
  logic              valid;
  logic              ready;
  logic              found;
  logic              status;
  logic [OCNT_W-1:0] entry_count;

  modport source (output valid, output found, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input found, input status, input entry_count,
                  output ready);
endinterface

// File: sv/id_whitelist_table.sv
// ----------------------------------------------------------------------------
// id_whitelist_table
// Unordered table of card identifiers with lookup, add and remove.
// ----------------------------------------------------------------------------
// The table lives in a ring of ENTRIES cells that rotates once per request
// past a single comparator at the head, so each transaction is accepted, runs
// a full rotation of the ring and then loads the response register; that load
// stalls while the previous response has not yet been taken. A finished
// response then waits in its register until it is taken, also while
// the next request is accepted. Lookup reports whether the identifier is held;
// add appends it when absent and reports status 1 when the table is full;
// remove drops it and closes the gap so the held identifiers stay packed at
// the front of the ring. Keys are cleaned before use: bytes after the first
// zero character, and beyond KEY_BYTES-1 characters, are ignored. The table
// comes out of reset empty; ring contents need no clearing.
// ----------------------------------------------------------------------------
`include "id_whitelist_table_assert.svh"

module id_whitelist_table import idwl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  idwl_in_if.sink    in_if,
  idwl_out_if.source out_if
);

  localparam logic [OCNT_W-1:0] FULL_CNT = OCNT_W'(ENTRIES);

  ring_ctrl_t ring;
  key_t       in_key;
  key_t       key_q;
  key_t       feed;
  key_t       cell_q [ENTRIES];
  key_t       cell_d [ENTRIES];

  // Clean the incoming key at the port; the sequencer latches it on acceptance.
  assign in_key = normalize_key(in_if.key_word0, in_if.key_word1, in_if.key_word2);

  // Sequencer: head compare, feed steering, entry count and response register.
  idwl_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .in_key (in_key),
    .head   (cell_q[0]),
    .ring   (ring),
    .key_q  (key_q)
  );

  // Feed the tail of the ring. Rotate the head back in, skip over a removed
  // entry by taking its successor, or insert the new key at the first free slot.
  always_comb begin
    case (ring.feed_sel)
      FEED_NEXT: feed = cell_q[1];
      FEED_KEY:  feed = key_q;
      default:   feed = cell_q[0];
    endcase
  end

  // Ring of cells: each cell takes its right neighbor; the last takes the feed.
  for (genvar k = 0; k < ENTRIES; k++) begin : g_ring
    if (k < ENTRIES - 1) begin : g_mid
      assign cell_d[k] = cell_q[k+1];
    end else begin : g_tail
      assign cell_d[k] = feed;
    end

    idwl_cell u_cell (
      .clk      (clk),
      .shift_en (ring.shift_en),
      .d        (cell_d[k]),
      .q        (cell_q[k])
    );
  end

  // No request is taken while the ring rotates.
  `IDWL_ASSERT_SAME(a_no_accept_in_scan, ring.shift_en, !in_if.ready, "request taken during scan")

  // An accepted request starts the rotation in the next cycle.
  `IDWL_ASSERT_NEXT(a_scan_follows_accept, in_if.valid && in_if.ready, ring.shift_en, "scan did not start")

  // A dropped add only happens on a full table and for an absent key.
  `IDWL_ASSERT_SAME(a_drop_when_full, out_if.valid && out_if.status,
                    !out_if.found && out_if.entry_count == FULL_CNT, "drop without full table")

endmodule

// File: sv/idwl_cell.sv
// ----------------------------------------------------------------------------
// idwl_cell
// One ring slot: holds a stored identifier and takes its neighbor's on a shift.
// ----------------------------------------------------------------------------
module idwl_cell import idwl_pkg::*; (
  input  logic clk,
  input  logic shift_en,
  input  key_t d,
  output key_t q
);

  key_t data_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      data_r <= d;
    end
  end

  assign q = data_r;

endmodule

// File: sv/idwl_ctrl.sv
// ----------------------------------------------------------------------------
// idwl_ctrl
// Scan sequencer: compares the ring head, steers the ring feed, keeps count.
// ----------------------------------------------------------------------------
module idwl_ctrl import idwl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  idwl_in_if.sink    in_if,
  idwl_out_if.source out_if,
  input  key_t       in_key,
  input  key_t       head,
  output ring_ctrl_t ring,
  output key_t       key_q
);

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  step_r, step_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              found_r, found_nxt;
  logic              status_r, status_nxt;
  logic [FUNC_W-1:0] func_r, func_nxt;
  key_t              key_r, key_nxt;
  res_t              res_r, res_nxt;

  logic hit;
  logic found_now;
  logic is_last;

  assign hit       = (state_r == ST_SCAN) && (CNT_W'(step_r) < count_r) && (head == key_r);
  assign found_now = found_r | hit;
  assign is_last   = (step_r == IDX_W'(ENTRIES - 1));

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    count_nxt     = count_r;
    found_nxt     = found_r;
    status_nxt    = status_r;
    func_nxt      = func_r;
    key_nxt       = key_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r & ~out_if.ready;
    in_if.ready   = 1'b0;
    ring.shift_en = 1'b0;
    ring.feed_sel = FEED_ROTATE;

    case (state_r)
      ST_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          key_nxt    = in_key;
          func_nxt   = in_if.func;
          step_nxt   = '0;
          found_nxt  = 1'b0;
          status_nxt = 1'b0;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ring.shift_en = 1'b1;
        // close the gap behind a removed entry; drop a new key into the first free slot
        if (func_r == FUNC_REMOVE && found_now) begin
          ring.feed_sel = FEED_NEXT;
        end else if (func_r == FUNC_ADD && !found_r && count_r == CNT_W'(step_r)) begin
          ring.feed_sel = FEED_KEY;
        end
        step_nxt  = step_r + IDX_W'(1);
        found_nxt = found_now;
        if (is_last) begin
          case (func_r)
            FUNC_ADD: begin
              if (!found_now) begin
                if (count_r == CNT_W'(ENTRIES)) begin
                  status_nxt = 1'b1;
                end else begin
                  count_nxt = count_r + CNT_W'(1);
                end
              end
            end
            FUNC_REMOVE: begin
              if (found_now) begin
                count_nxt = count_r - CNT_W'(1);
              end
            end
            default: begin
            end
          endcase
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          res_nxt.found       = found_r;
          res_nxt.status      = status_r;
          res_nxt.entry_count = OCNT_W'(count_r);
          out_valid_nxt       = 1'b1;
          state_nxt           = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r   <= step_nxt;
    status_r <= status_nxt;
    func_r   <= func_nxt;
    key_r    <= key_nxt;
    res_r    <= res_nxt;
  end

  assign key_q              = key_r;
  assign out_if.valid       = out_valid_r;
  assign out_if.found       = res_r.found;
  assign out_if.status      = res_r.status;
  assign out_if.entry_count = res_r.entry_count;

endmodule

// File: tb/idwl_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// idwl_table_checker
// Watches both channels of the ID table, keeps a shadow table, predicts the
// response of every accepted request and compares it field by field with the
// responses as they leave the block.
// ----------------------------------------------------------------------------
module idwl_table_checker import idwl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  idwl_in_if   in_ch,
  idwl_out_if  out_ch,
  output int   fail_total,
  output int   pending,
  output int   checked,
  output int   full_drops,
  output int   peak_count
);

  key_t        id_shadow [ENTRIES];
  int unsigned shadow_count;
  res_t        expected_responses [$];
  int          fails;
  int          n_checked;
  int          n_drops;
  int          n_peak;

  // Strip everything from the first zero character on, and past the limit.
  function automatic key_t clean_id(input logic [63:0] w0, input logic [63:0] w1,
                                    input logic [55:0] w2);
    key_t raw;
    int   n;
    raw = {w2, w1, w0};
    n   = 0;
    while (n < CHAR_LIMIT && raw[n*8 +: 8] != 8'h00) n++;
    return raw & ((key_t'(1) << (n * 8)) - key_t'(1));
  endfunction

  // Apply one request to the shadow table and return its response.
  function automatic res_t apply_request(input logic [FUNC_W-1:0] op, input key_t k);
    res_t        r;
    logic        hit;
    int unsigned slot;
    hit  = 1'b0;
    slot = 0;
    for (int unsigned i = 0; i < shadow_count; i++) begin
      if (!hit && id_shadow[i] == k) begin
        hit  = 1'b1;
        slot = i;
      end
    end
    r.found  = hit;
    r.status = 1'b0;
    if (op == FUNC_ADD && !hit) begin
      if (shadow_count >= ENTRIES) begin
        r.status = 1'b1;
        n_drops++;
      end else begin
        id_shadow[shadow_count] = k;
        shadow_count++;
      end
    end else if (op == FUNC_REMOVE && hit) begin
      // Close the gap with the last entry.
      id_shadow[slot] = id_shadow[shadow_count - 1];
      shadow_count--;
    end
    if (shadow_count > n_peak) n_peak = shadow_count;
    r.entry_count = shadow_count[OCNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      shadow_count = 0;
      expected_responses.delete();
      fails     = 0;
      n_checked = 0;
      n_drops   = 0;
      n_peak    = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_responses.size() == 0) begin
          $error("response with no request outstanding");
          fails++;
        end else begin
          want = expected_responses.pop_front();
          n_checked++;
          if (out_ch.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, out_ch.found);
            fails++;
          end
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            fails++;
          end
          if (out_ch.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   out_ch.entry_count);
            fails++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_responses.push_back(apply_request(in_ch.func,
            clean_id(in_ch.key_word0, in_ch.key_word1, in_ch.key_word2)));
      end
    end
    fail_total <= fails;
    pending    <= expected_responses.size();
    checked    <= n_checked;
    full_drops <= n_drops;
    peak_count <= n_peak;
  end

endmodule

// File: tb/tb_id_whitelist_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_id_whitelist_table
// Drives lookup, add and remove transactions into the ID table under random
// idling on both channels and gives the verdict; all checking is done by the
// table checker that sits beside the block.
// ----------------------------------------------------------------------------
// A short directed part walks the corner keys (empty, full length, junk after
// the terminator, the unused operation code, add of a held key, remove of a
// missing one). The random part then fills the table past full from a pool of
// identifiers, churns it while full and drains it again.
// ----------------------------------------------------------------------------
module tb_id_whitelist_table;
  import idwl_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int POOL_SIZE      = 300;
  localparam int RANDOM_ITEMS   = 1000;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 300;

  logic clk;
  logic rst_n;

  idwl_in_if  in_ch ();
  idwl_out_if out_ch ();

  int fail_total;
  int pending;
  int checked;
  int full_drops;
  int peak_count;

  // Idle percentages for sender and receiver; the stimulus process sets them.
  int in_idle_pct;
  int out_idle_pct;
  int stall_left;
  int quiet_cycles;

  // Identifier pool: normalized keys and their character lengths.
  key_t pool_key [POOL_SIZE];
  int   pool_len [POOL_SIZE];
  int   next_seq;

  id_whitelist_table uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  idwl_table_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_total (fail_total),
    .pending    (pending),
    .checked    (checked),
    .full_drops (full_drops),
    .peak_count (peak_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: drop ready at random, and now and then hold a long stall so
  // that backpressure lands on every phase of the block's scan.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (out_idle_pct > 0 && $urandom_range(0, 999) < 3) begin
      out_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(1, 600);
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Fully random 184-bit raw key: every bit position takes both values.
  function automatic key_t random_raw();
    return key_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
  endfunction

  // Pool identifier, optionally with junk bytes after its terminator.
  function automatic key_t pool_variant(input int idx);
    key_t k;
    k = pool_key[idx];
    if ($urandom_range(0, 1) == 1) begin
      for (int p = pool_len[idx] + 1; p < MAX_CHARS; p++) begin
        k[p*8 +: 8] = 8'($urandom_range(0, 255));
      end
    end
    return k;
  endfunction

  // Offer one transaction and hold it until the block takes it. Valid is
  // only lowered when this transaction idles first, never in the step that
  // raises it again.
  task automatic send_request(input logic [FUNC_W-1:0] op, input key_t raw);
    if (in_idle_pct > 0 && $urandom_range(0, 99) < 5) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 300)) @(posedge clk);
    end
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= op;
    in_ch.key_word0 <= raw[63:0];
    in_ch.key_word1 <= raw[127:64];
    in_ch.key_word2 <= raw[183:128];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Pick one random transaction; the mix shifts from filling the table to
  // churning it while full and finally draining it.
  task automatic send_random(input int n);
    int          r;
    int          idx;
    logic [FUNC_W-1:0] op;
    key_t        k;
    r   = $urandom_range(0, 99);
    idx = $urandom_range(0, POOL_SIZE - 1);
    k   = pool_variant(idx);
    if (n < 400) begin
      if (r < 3) begin
        op = FUNC_W'($urandom_range(0, 3));
        k  = random_raw();
      end else if (r < 15) begin
        op = ($urandom_range(0, 4) == 0) ? FUNC_UNUSED : FUNC_LOOKUP;
      end else if (r < 20) begin
        op = FUNC_REMOVE;
      end else begin
        op = FUNC_ADD;
        // Walk the pool in order most of the time so the table fills up.
        if ($urandom_range(0, 99) < 85) begin
          k        = pool_variant(next_seq);
          next_seq = (next_seq + 1) % POOL_SIZE;
        end
      end
    end else if (n < 700) begin
      if (r < 5) begin
        op = FUNC_W'($urandom_range(0, 3));
        k  = random_raw();
      end else if (r < 30) begin
        op = ($urandom_range(0, 4) == 0) ? FUNC_UNUSED : FUNC_LOOKUP;
      end else if (r < 55) begin
        op = FUNC_REMOVE;
      end else begin
        op = FUNC_ADD;
      end
    end else begin
      if (r < 5) begin
        op = FUNC_W'($urandom_range(0, 3));
        k  = random_raw();
      end else if (r < 25) begin
        op = ($urandom_range(0, 4) == 0) ? FUNC_UNUSED : FUNC_LOOKUP;
      end else if (r < 40) begin
        op = FUNC_ADD;
      end else begin
        op = FUNC_REMOVE;
      end
    end
    send_request(op, k);
  endtask

  initial begin
    // Drive the request side to a known value before the first edge; the
    // receiver process owns ready.
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.func      <= FUNC_LOOKUP;
    in_ch.key_word0 <= '0;
    in_ch.key_word1 <= '0;
    in_ch.key_word2 <= '0;
    in_idle_pct  = 34;
    out_idle_pct = 58;
    next_seq     = 0;

    // Build the pool: slot 0 is the empty identifier, the rest have 1 to 23
    // nonzero characters.
    pool_key[0] = '0;
    pool_len[0] = 0;
    for (int i = 1; i < POOL_SIZE; i++) begin
      pool_len[i] = $urandom_range(1, MAX_CHARS);
      pool_key[i] = '0;
      for (int p = 0; p < pool_len[i]; p++) begin
        pool_key[i][p*8 +: 8] = 8'($urandom_range(1, 255));
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed corners on an empty, then lightly used table.
    send_request(FUNC_LOOKUP, '0);
    send_request(FUNC_REMOVE, '0);
    send_request(FUNC_ADD, '0);
    // Empty identifier again, with junk behind the terminator.
    send_request(FUNC_ADD, {56'hFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                            64'hFFFF_FFFF_FFFF_FF00});
    send_request(FUNC_LOOKUP, '1);
    send_request(FUNC_ADD, '1);
    send_request(FUNC_UNUSED, '1);
    send_request(FUNC_UNUSED, {56'h0, 64'h0, 64'h41});
    send_request(FUNC_ADD, {56'hFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                            64'hDEAD_BEEF_CAFE_0041});
    send_request(FUNC_LOOKUP, {56'h0, 64'h0, 64'h41});
    send_request(FUNC_ADD, {56'h0, 64'h0, 64'h01});
    send_request(FUNC_ADD, {56'h12_3456_789A_BCDE, 64'hFFFF_FFFF_FFFF_FF00,
                            64'h0807_0605_0403_0201});
    send_request(FUNC_ADD, {56'h0, 64'h504F_4E4D_4C4B_4A49, 64'h4847_4645_4443_4241});
    send_request(FUNC_LOOKUP, {56'hFF_FFFF_FFFF_FF00, 64'h504F_4E4D_4C4B_4A49,
                               64'h4847_4645_4443_4241});
    send_request(FUNC_ADD, {56'h00_1615_1413_1211, 64'h100F_0E0D_0C0B_0A09,
                            64'h0807_0605_0403_0201});
    send_request(FUNC_REMOVE, '0);
    send_request(FUNC_LOOKUP, {56'hAB_1615_1413_1211, 64'h100F_0E0D_0C0B_0A09,
                               64'h0807_0605_0403_0201});
    send_request(FUNC_REMOVE, {56'h00_1615_1413_1211, 64'h100F_0E0D_0C0B_0A09,
                               64'h0807_0605_0403_0201});
    send_request(FUNC_REMOVE, '1);
    send_request(FUNC_REMOVE, {56'h0, 64'h0, 64'h41});
    send_request(FUNC_REMOVE, {56'h0, 64'h0, 64'h41});
    send_request(FUNC_LOOKUP, '0);

    // Random part: swap the idle roles at one third, stop idling at two.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        in_idle_pct  = 58;
        out_idle_pct = 34;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      send_random(n);
    end
    in_ch.valid <= 1'b0;

    // Let the checker see the last request, then wait for every response.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d responses; table peaked at %0d of %0d entries.",
             checked, peak_count, ENTRIES);
    $display("Adds dropped on a full table: %0d.", full_drops);
    if (fail_total == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
